/* hw/rtl/upi_pkg.sv */
// ----------------------------------------------------------------------------
// upi_pkg
// Shared constants, codes, CORDIC tables and types of the pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 24;

    // CORDIC datapath: Q22 sine/cosine, Q16 angle
    localparam int CS_W         = 26;
    localparam int ANG_W        = 21;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 5;

    localparam logic signed [CS_W-1:0]  CORDIC_GAIN    = 26'sd2547003;
    localparam logic signed [ANG_W-1:0] CORDIC_PI      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] CORDIC_HALF_PI = 21'sd102944;

    // configuration port
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [15:0] DT_RESET      = 16'd1049;
    localparam logic [22:0] WIDTH_RESET   = 23'd726721;
    localparam logic [22:0] HEIGHT_RESET  = 23'd726721;
    localparam logic [15:0] TIMEOUT_RESET = 16'd62;

    // item function codes
    localparam logic [1:0] FUNC_VEL  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_REL  = 2'd2;
    localparam logic [1:0] FUNC_ABS  = 2'd3;

    localparam longint PI_Q32 = 64'sh3243F6A88;

    // round(pi * 2^f)
    function automatic longint pi_fix(input int f);
        return (PI_Q32 + (64'sd1 <<< (31 - f))) >>> (32 - f);
    endfunction

    // atan(2^-i) in Q16
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } t_cordic_res;

endpackage

/* hw/rtl/upi_mul.sv */
// ----------------------------------------------------------------------------
// upi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module upi_mul #(
    parameter int A_W = 26,
    parameter int B_W = 26
) (
    input  logic                       i_clk,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/upi_cordic.sv */
// ----------------------------------------------------------------------------
// upi_cordic
// Iterative rotation CORDIC: one rotation step per cycle, Q22 cos/sin out.
// ----------------------------------------------------------------------------
module upi_cordic #(
    parameter int FRAC_BITS = upi_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = upi_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WORD_BITS-1:0] i_angle,
    output upi_pkg::t_cordic_res        o_res
);

    localparam int DOWN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int UP   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int QW   = WORD_BITS + UP + upi_pkg::ANG_W;
    localparam int CW   = upi_pkg::CS_W;
    localparam int AW   = upi_pkg::ANG_W;

    logic signed [QW-1:0] w_ext;
    logic signed [AW-1:0] w_a0;
    logic signed [AW-1:0] w_fold;
    logic                 w_neg;

    logic                            r_busy;
    logic                            r_done;
    logic [upi_pkg::STEP_W-1:0]      r_i;
    logic signed [CW-1:0]            r_x;
    logic signed [CW-1:0]            r_y;
    logic signed [AW-1:0]            r_a;
    logic                            r_neg;
    logic signed [CW-1:0]            r_cos;
    logic signed [CW-1:0]            r_sin;

    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [AW-1:0] n_a;

    // angle to Q16 (floor), then fold into [-pi/2, pi/2]
    assign w_ext = (QW'(i_angle) <<< UP) >>> DOWN;
    assign w_a0  = w_ext[AW-1:0];

    always_comb begin
        w_fold = w_a0;
        w_neg  = 1'b0;
        if (w_a0 > upi_pkg::CORDIC_HALF_PI) begin
            w_fold = w_a0 - upi_pkg::CORDIC_PI;
            w_neg  = 1'b1;
        end else if (w_a0 < -upi_pkg::CORDIC_HALF_PI) begin
            w_fold = w_a0 + upi_pkg::CORDIC_PI;
            w_neg  = 1'b1;
        end
    end

    always_comb begin
        if (!r_a[AW-1]) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_a = r_a - upi_pkg::atan_q16(r_i);
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_a = r_a + upi_pkg::atan_q16(r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= upi_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_a    <= w_fold;
                r_neg  <= w_neg;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_a <= n_a;
                r_i <= r_i + 1'b1;
                if (r_i == upi_pkg::STEP_W'(upi_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cos  <= r_neg ? -n_x : n_x;
                    r_sin  <= r_neg ? -n_y : n_y;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_cos;
    assign o_res.sin_v = r_sin;

endmodule

/* hw/rtl/unicycle_pose_integrator.sv */
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Dead-reckoning pose integrator with a shared CORDIC and shared multiplier.
// ----------------------------------------------------------------------------
// Sequence per item: a tick first multiplies ang*dt; then a heading wrap of MODK+1
//   steps (9 at default parameters), the CORDIC and four multiplies on the shared multiplier.
// Flow: not ready while an item is in work; the next item may enter while a result waits.
// Reset: synchronous active low; pose, speeds, idle count clear, config to defaults.
module unicycle_pose_integrator #(
    parameter int FRAC_BITS = upi_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = upi_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [upi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [upi_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [WORD_BITS-1:0]       i_lin_vel_cmd,
    input  logic signed [WORD_BITS-1:0]       i_ang_vel_cmd,
    input  logic signed [WORD_BITS-1:0]       i_tp_x,
    input  logic signed [WORD_BITS-1:0]       i_tp_y,
    input  logic signed [WORD_BITS-1:0]       i_tp_angle,
    input  logic signed [WORD_BITS-1:0]       i_tp_distance,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [WORD_BITS-1:0]       o_pos_x,
    output logic signed [WORD_BITS-1:0]       o_pos_y_up,
    output logic signed [WORD_BITS-1:0]       o_heading,
    output logic signed [WORD_BITS-1:0]       o_lin_speed,
    output logic signed [WORD_BITS-1:0]       o_ang_speed,
    output logic signed [WORD_BITS-1:0]       o_vel_x,
    output logic signed [WORD_BITS-1:0]       o_vel_y,
    output logic                              o_hit_wall,
    output logic                              o_changed
);

    localparam int W    = WORD_BITS;
    localparam int MODK = ((W - FRAC_BITS - 1 > 0) ? W - FRAC_BITS - 1 : 0) + 1;
    localparam int MX0  = (W > FRAC_BITS) ? W : FRAC_BITS;
    localparam int MX   = (MX0 > 24) ? MX0 : 24;
    localparam int EW   = MX + 6;
    localparam int KW   = $clog2(MODK + 1);
    localparam int AMW  = W + 2;
    localparam int BMW  = upi_pkg::CS_W;
    localparam int PW   = AMW + BMW;

    localparam logic signed [EW-1:0] PI_E  = EW'(upi_pkg::pi_fix(FRAC_BITS));
    localparam logic signed [EW-1:0] TOP_E = EW'((2 * upi_pkg::pi_fix(FRAC_BITS)) <<< MODK);
    localparam logic signed [EW-1:0] SAT_HI = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AMUL  = 4'd1;
    localparam logic [3:0] S_WINIT = 4'd2;
    localparam logic [3:0] S_WSTEP = 4'd3;
    localparam logic [3:0] S_WFIN  = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MACC  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // configuration
    logic [15:0] r_dt;
    logic [22:0] r_cw;
    logic [22:0] r_ch;
    logic [15:0] r_to;

    // state
    logic [3:0]            r_state;
    logic [1:0]            r_func;
    logic signed [W-1:0]   r_dist;
    logic signed [W-1:0]   r_tpa;
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_y;
    logic signed [W-1:0]   r_head;
    logic signed [W-1:0]   r_old_head;
    logic signed [W-1:0]   r_lin;
    logic signed [W-1:0]   r_ang;
    logic [15:0]           r_idle;
    logic signed [EW-1:0]  r_acc;
    logic signed [EW-1:0]  r_sub;
    logic [KW-1:0]         r_k;
    logic [1:0]            r_mstep;
    logic signed [AMW-1:0] r_vxq;
    logic signed [AMW-1:0] r_vyq;
    logic signed [AMW-1:0] r_dx;
    logic signed [AMW-1:0] r_dy;
    logic                  r_hit;
    logic                  r_chg;
    logic                  r_out_valid;

    upi_pkg::t_cordic_res  w_cs;
    logic signed [AMW-1:0] w_ma;
    logic signed [BMW-1:0] w_mb;
    logic signed [PW-1:0]  w_prod;
    logic signed [AMW-1:0] w_p22;
    logic signed [AMW-1:0] w_p16;
    logic signed [BMW-1:0] w_dt_s;
    logic signed [EW-1:0]  w_h;
    logic signed [EW-1:0]  w_init;
    logic signed [W-1:0]   w_ang;
    logic signed [EW-1:0]  w_cw_e;
    logic signed [EW-1:0]  w_ch_e;
    logic signed [EW-1:0]  w_nx;
    logic signed [EW-1:0]  w_ny;
    logic signed [EW-1:0]  w_cx;
    logic signed [EW-1:0]  w_cy;
    logic signed [W-1:0]   w_sx;
    logic signed [W-1:0]   w_sy;
    logic signed [EW-1:0]  w_abs_y;
    logic                  w_accept;
    logic                  w_load;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_dt_s   = BMW'($signed({1'b0, r_dt}));
    assign w_cw_e   = EW'($signed({1'b0, r_cw}));
    assign w_ch_e   = EW'($signed({1'b0, r_ch}));
    assign w_p22    = $signed(w_prod[22 +: AMW]);
    assign w_p16    = $signed(w_prod[16 +: AMW]);

    // multiplier operand select
    always_comb begin
        w_ma = AMW'(r_lin);
        w_mb = w_cs.cos_v;
        if (r_state == S_AMUL) begin
            w_ma = AMW'(r_ang);
            w_mb = w_dt_s;
        end else begin
            case (r_mstep)
                2'd0: begin
                    w_ma = AMW'(r_lin);
                    w_mb = w_cs.cos_v;
                end
                2'd1: begin
                    w_ma = (r_func == upi_pkg::FUNC_TICK) ? r_vxq : AMW'(r_dist);
                    w_mb = (r_func == upi_pkg::FUNC_TICK) ? w_dt_s : w_cs.cos_v;
                end
                2'd2: begin
                    w_ma = AMW'(r_lin);
                    w_mb = w_cs.sin_v;
                end
                default: begin
                    w_ma = (r_func == upi_pkg::FUNC_TICK) ? r_vyq : AMW'(r_dist);
                    w_mb = (r_func == upi_pkg::FUNC_TICK) ? w_dt_s : w_cs.sin_v;
                end
            endcase
        end
    end

    upi_mul #(
        .A_W(AMW),
        .B_W(BMW)
    ) u_mul (
        .i_clk(i_clk),
        .i_a  (w_ma),
        .i_b  (w_mb),
        .o_p  (w_prod)
    );

    // heading before wrap
    always_comb begin
        case (r_func)
            upi_pkg::FUNC_TICK: w_h = EW'(r_head) + EW'(w_p16);
            upi_pkg::FUNC_REL:  w_h = EW'(r_head) + EW'(r_tpa);
            default:            w_h = EW'(r_head);
        endcase
    end

    assign w_init = w_h + PI_E;
    assign w_ang  = sat_w(r_acc - PI_E);

    upi_cordic #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_WFIN),
        .i_angle(w_ang),
        .o_res  (w_cs)
    );

    // position update for tick and relative moves, canvas clamp for ticks
    assign w_nx = EW'(r_x) + EW'(r_dx);
    assign w_ny = EW'(r_y) - EW'(r_dy);
    assign w_cx = w_nx[EW-1] ? '0 : ((w_nx > w_cw_e) ? w_cw_e : w_nx);
    assign w_cy = w_ny[EW-1] ? '0 : ((w_ny > w_ch_e) ? w_ch_e : w_ny);
    assign w_sx = sat_w(w_cx);
    assign w_sy = sat_w(w_cy);
    assign w_abs_y = w_ch_e - EW'(i_tp_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= upi_pkg::DT_RESET;
            r_cw <= upi_pkg::WIDTH_RESET;
            r_ch <= upi_pkg::HEIGHT_RESET;
            r_to <= upi_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                upi_pkg::CFG_DT:     r_dt <= i_cfg_data[15:0];
                upi_pkg::CFG_WIDTH:  r_cw <= i_cfg_data;
                upi_pkg::CFG_HEIGHT: r_ch <= i_cfg_data;
                default:             r_to <= i_cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_lin       <= '0;
            r_ang       <= '0;
            r_idle      <= '0;
            r_mstep     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_func;
                        r_dist <= i_tp_distance;
                        r_tpa  <= i_tp_angle;
                        r_state <= (i_func == upi_pkg::FUNC_TICK) ? S_AMUL : S_WINIT;
                        case (i_func)
                            upi_pkg::FUNC_VEL: begin
                                r_lin  <= i_lin_vel_cmd;
                                r_ang  <= i_ang_vel_cmd;
                                r_idle <= '0;
                            end
                            upi_pkg::FUNC_TICK: begin
                                if (r_idle > r_to) begin
                                    r_lin <= '0;
                                    r_ang <= '0;
                                end
                                if (r_idle != 16'hFFFF)
                                    r_idle <= r_idle + 16'd1;
                            end
                            upi_pkg::FUNC_ABS: begin
                                r_x    <= i_tp_x;
                                r_head <= i_tp_angle;
                                r_y    <= sat_w(w_abs_y[EW-1] ? '0 : w_abs_y);
                            end
                            default: ;
                        endcase
                    end
                end
                S_AMUL: r_state <= S_WINIT;
                S_WINIT: begin
                    r_old_head <= r_head;
                    r_acc   <= w_init[EW-1] ? w_init + TOP_E : w_init;
                    r_sub   <= TOP_E;
                    r_k     <= KW'(MODK);
                    r_state <= S_WSTEP;
                end
                S_WSTEP: begin
                    if (r_acc >= r_sub)
                        r_acc <= r_acc - r_sub;
                    r_sub <= r_sub >>> 1;
                    if (r_k == '0)
                        r_state <= S_WFIN;
                    else
                        r_k <= r_k - 1'b1;
                end
                S_WFIN: begin
                    if (r_func == upi_pkg::FUNC_TICK || r_func == upi_pkg::FUNC_REL)
                        r_head <= w_ang;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (w_cs.done) begin
                        r_mstep <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_MACC;
                S_MACC: begin
                    case (r_mstep)
                        2'd0:    r_vxq <= w_p22;
                        2'd1:    r_dx  <= (r_func == upi_pkg::FUNC_TICK) ? w_p16 : w_p22;
                        2'd2:    r_vyq <= w_p22;
                        default: r_dy  <= (r_func == upi_pkg::FUNC_TICK) ? w_p16 : w_p22;
                    endcase
                    if (r_mstep == 2'd3) begin
                        r_state <= S_UPD;
                    end else begin
                        r_mstep <= r_mstep + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_UPD: begin
                    case (r_func)
                        upi_pkg::FUNC_VEL: begin
                            r_hit <= 1'b0;
                            r_chg <= 1'b0;
                        end
                        upi_pkg::FUNC_TICK: begin
                            r_hit <= w_nx[EW-1] || (w_nx > w_cw_e) ||
                                     w_ny[EW-1] || (w_ny > w_ch_e);
                            r_chg <= (r_head != r_old_head) || (w_sx != r_x) ||
                                     (w_sy != r_y);
                            r_x <= w_sx;
                            r_y <= w_sy;
                        end
                        upi_pkg::FUNC_REL: begin
                            r_hit <= 1'b0;
                            r_chg <= 1'b1;
                            r_x   <= sat_w(w_nx);
                            r_y   <= sat_w(w_ny);
                        end
                        default: begin
                            r_hit <= 1'b0;
                            r_chg <= 1'b1;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_pos_x     <= r_x;
            o_pos_y_up  <= sat_w(w_ch_e - EW'(r_y));
            o_heading   <= r_head;
            o_lin_speed <= r_lin;
            o_ang_speed <= r_ang;
            o_vel_x     <= sat_w(EW'(r_vxq));
            o_vel_y     <= sat_w(EW'(r_vyq));
            o_hit_wall  <= r_hit;
            o_changed   <= r_chg;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready right after an accepted item");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)))
        else $error("pending result dropped or changed");

    a_cordic_follows_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WFIN) |=> (r_state == S_CORD))
        else $error("CORDIC not started after wrap");

    a_vel_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_func == upi_pkg::FUNC_VEL) |=> (!o_changed && !o_hit_wall))
        else $error("velocity command reported a pose change");

    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_func == upi_pkg::FUNC_TICK) |->
        (EW'(r_head) >= -PI_E && EW'(r_head) < PI_E))
        else $error("tick heading outside wrap range");

endmodule
